>>> rtl/bae_pkg.sv
// package for the binary arithmetic encoder core
// holds the queue item type and the range engine state encoding, no dependencies
`default_nettype none

package bae_pkg;

    localparam int unsigned ProbW = 12;
    localparam int unsigned ByteW = 8;
    localparam int unsigned RangeW = 32;
    localparam int unsigned MaxBytes = 4;

    typedef struct packed {
        logic [ProbW-1:0] probability;
        logic             bit_value;
    } bae_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_EMIT
    } bae_state_t;

endpackage

`default_nettype wire

>>> rtl/bae_front.sv
// front part of the encoder: input transfer and item queue
// uses bae_pkg for the item type
`default_nettype none

module bae_front #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire bae_pkg::bae_item_t in_item,
    input  wire logic               pop,
    output logic                    not_empty,
    output bae_pkg::bae_item_t      head_item
);
    import bae_pkg::*;

    localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    bae_item_t       mem [QUEUE_DEPTH];
    bae_item_t       head_reg;
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push;

    assign s_tready  = (count_reg != FullCnt);
    assign push      = s_tvalid && s_tready;
    assign not_empty = (count_reg != '0);
    assign head_item = head_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage and registered read port
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
        if (pop) begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bae_back.sv
// back part of the encoder: interval update and byte shift-out
// uses bae_pkg for the item type and the sequencer states
`default_nettype none

module bae_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               not_empty,
    input  wire bae_pkg::bae_item_t head_item,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast
);
    import bae_pkg::*;

    localparam logic [1:0] LastCount = 2'(MaxBytes - 1);

    bae_state_t        state_reg, state_next;
    logic [RangeW-1:0] low_reg, low_next;
    logic [RangeW-1:0] high_reg, high_next;
    logic [RangeW-1:0] span_reg, span_next;   // always high - low
    logic [RangeW-1:0] prod_reg, prod_next;
    logic              bit_reg, bit_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic [ByteW-1:0]  data_reg, data_next;
    logic              last_reg, last_next;

    logic [RangeW-1:0] split;
    logic              top_match;
    logic              out_free;
    logic              emit_last;

    assign split     = low_reg + prod_reg;
    assign top_match = (low_reg[31:24] == high_reg[31:24]);
    assign out_free  = !valid_reg || m_tready;
    assign emit_last = (low_reg[23:16] != high_reg[23:16]) || (cnt_reg == LastCount);

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (not_empty) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!top_match) begin
                    state_next = ST_IDLE;
                end else if (out_free && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pop        = 1'b0;
        low_next   = low_reg;
        high_next  = high_reg;
        span_next  = span_reg;
        prod_next  = prod_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                pop      = not_empty;
                cnt_next = '0;
            end
            ST_MUL: begin
                prod_next = RangeW'(span_reg[31:12]) * RangeW'(head_item.probability);
                bit_next  = head_item.bit_value;
            end
            ST_UPDATE: begin
                if (bit_reg) begin
                    high_next = split;
                    span_next = prod_reg;
                end else begin
                    low_next  = split + 1'b1;
                    span_next = span_reg - prod_reg - 1'b1;
                end
            end
            ST_EMIT: begin
                if (top_match && out_free) begin
                    valid_next = 1'b1;
                    data_next  = high_reg[31:24];
                    last_next  = emit_last;
                    low_next   = {low_reg[23:0], 8'h00};
                    high_next  = {high_reg[23:0], 8'hff};
                    span_next  = {span_reg[23:0], 8'hff};
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            low_reg   <= '0;
            high_reg  <= '1;
            span_reg  <= '1;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            span_reg  <= span_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        bit_reg  <= bit_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

>>> rtl/binary_arithmetic_encoder_core.sv
// top level of the binary arithmetic encoder: front queue plus range engine
// depends on bae_pkg, bae_front and bae_back
`default_nettype none

// Binary arithmetic encoder with 12-bit probabilities. Each input transfer carries one
// bit and the chance (scaled by 4096) that it is a one; the core narrows a 32-bit
// interval and sends out every settled top byte as one output transfer, zero to four
// per bit, with tlast on the final byte of each bit. No flush is done here. Input
// transfers go into a small queue (QUEUE_DEPTH entries), so the source keeps running
// while the range engine is busy or the sink stalls. The range engine works on one bit
// at a time: the IDLE state reads the queue, MUL does the 20x12 multiply, UPDATE moves
// the bounds and EMIT sends the settled bytes, waiting while the sink is not ready,
// until no further byte settles or four are out. That sequencer sets the sustained rate;
// the queue only hides bursts. Reset needs no clearing pass.
module binary_arithmetic_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [0] bit_value, [12:1] probability, [15:13] zero
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] code_byte
    output logic             m_tlast    // last_byte
);
    import bae_pkg::*;

    bae_item_t in_item;
    bae_item_t head_item;
    logic      q_pop;
    logic      q_not_empty;

    // unpack the input transfer, padding bits are ignored
    assign in_item.bit_value   = s_tdata[0];
    assign in_item.probability = s_tdata[12:1];

    bae_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_item   (in_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    bae_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (q_not_empty),
        .head_item (head_item),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // the engine never reads an empty queue
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("queue read while empty");

    // reads are spaced by the multiply and update cycles
    a_pop_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !q_pop)
        else $error("queue read on consecutive cycles");

    // an accepted transfer leaves the queue non-empty
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> q_not_empty)
        else $error("accepted transfer lost by the queue");

    // reset drops any pending output transfer
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
